### rtl/core/ieb_pkg.sv
// Shared types and constants for the I2C EEPROM byte master.
package ieb_pkg;

	localparam int IN_W  = 24;
	localparam int OUT_W = 16;

	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_READ   = 2'd1,
		ACT_WRITE  = 2'd2,
		ACT_VERIFY = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_ACK   = 2'd1,
		ST_MISMATCH = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_START    = 5'd1,
		PH_DEVW_TX  = 5'd2,
		PH_DEVW_ACK = 5'd3,
		PH_ADDR_TX  = 5'd4,
		PH_ADDR_ACK = 5'd5,
		PH_DATA_TX  = 5'd6,
		PH_DATA_ACK = 5'd7,
		PH_WSTOP    = 5'd8,
		PH_WWAIT    = 5'd9,
		PH_RSTART   = 5'd10,
		PH_DEVR_TX  = 5'd11,
		PH_DEVR_ACK = 5'd12,
		PH_RX       = 5'd13,
		PH_RX_NACK  = 5'd14,
		PH_RSTOP    = 5'd15,
		PH_FSTOP    = 5'd16
	} phase_t;

	localparam logic [2:0] REG_HALF_BIT      = 3'd0;
	localparam logic [2:0] REG_POLL_LIMIT    = 3'd1;
	localparam logic [2:0] REG_POLL_INTERVAL = 3'd2;
	localparam logic [2:0] REG_WRITE_WAIT    = 3'd3;
	localparam logic [2:0] REG_DEVICE        = 3'd4;

	localparam logic [7:0]  HALF_BIT_RST      = 8'd5;
	localparam logic [7:0]  POLL_LIMIT_RST    = 8'd250;
	localparam logic [15:0] POLL_INTERVAL_RST = 16'd1000;
	localparam logic [15:0] WRITE_WAIT_RST    = 16'd10000;
	localparam logic [6:0]  DEVICE_RST        = 7'h50;

	typedef struct packed {
		logic [7:0]  half_bit_ticks;
		logic [7:0]  ack_poll_limit;
		logic [15:0] ack_poll_interval;
		logic [15:0] write_wait_ticks;
		logic [6:0]  device_select;
	} cfg_t;

	typedef struct packed {
		logic       is_cmd;
		action_t    action;
		logic [7:0] mem_address;
		logic [7:0] write_data;
		logic       sda_in;
	} item_t;

	function automatic logic is_tx(phase_t p);
		return p == PH_DEVW_TX || p == PH_ADDR_TX || p == PH_DATA_TX || p == PH_DEVR_TX;
	endfunction

	function automatic logic is_ack(phase_t p);
		return p == PH_DEVW_ACK || p == PH_ADDR_ACK || p == PH_DATA_ACK ||
			p == PH_DEVR_ACK;
	endfunction

endpackage

### rtl/core/ieb_front.sv
// Input stage: accept tick words, classify them and queue them for the engine.
module ieb_front import ieb_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [IN_W-1:0] s_tdata,
	input  logic            pop,
	output logic            item_valid,
	output item_t           item
);

	item_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	item_t       in_item;

	assign s_tready   = count_q != 2'd2;
	assign push       = s_tvalid && s_tready;
	assign item_valid = count_q != 2'd0;
	assign item       = mem_q[rd_ptr_q];

	always_comb begin
		in_item.action      = action_t'(s_tdata[1:0]);
		in_item.mem_address = s_tdata[9:2];
		in_item.write_data  = s_tdata[17:10];
		in_item.sda_in      = s_tdata[18];
		in_item.is_cmd      = action_t'(s_tdata[1:0]) != ACT_TICK;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/core/ieb_engine.sv
// Bus sequencer: advance the I2C transfer one tick per queued word and register the result.
module ieb_engine import ieb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             item_valid,
	input  item_t            item,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	phase_t      phase_q, phase_d;
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] tick_q, tick_d;
	logic [7:0]  poll_q, poll_d;
	action_t     op_q, op_d;
	logic [7:0]  addr_q, addr_d;
	logic [7:0]  data_q, data_d;
	logic [7:0]  rx_q, rx_d;
	status_t     status_q, status_d;
	logic        done_d;

	logic [15:0] tc_inc;
	logic [15:0] dur;
	logic        seg_end;
	logic [7:0]  dev_w;
	logic [7:0]  rx_shift;

	logic        scl_d, sdl_d, en_d;
	logic        out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	assign pop      = item_valid && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign dev_w    = {cfg.device_select, 1'b0};
	assign tc_inc   = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;
	assign rx_shift = {shift_q[6:0], item.sda_in};

	always_comb begin
		if (phase_q == PH_WWAIT) begin
			dur = cfg.write_wait_ticks;
		end else if (is_ack(phase_q) && bit_q == 4'd1 && poll_q != 8'd0) begin
			dur = cfg.ack_poll_interval;
		end else begin
			dur = {8'd0, cfg.half_bit_ticks};
		end
	end

	assign seg_end = tc_inc >= dur;

	// next state
	always_comb begin
		phase_d  = phase_q;
		bit_d    = bit_q;
		shift_d  = shift_q;
		tick_d   = tick_q;
		poll_d   = poll_q;
		op_d     = op_q;
		addr_d   = addr_q;
		data_d   = data_q;
		rx_d     = rx_q;
		status_d = status_q;
		done_d   = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (item.is_cmd) begin
				addr_d  = item.mem_address;
				data_d  = item.write_data;
				op_d    = item.action;
				phase_d = PH_START;
				bit_d   = 4'd0;
				tick_d  = 16'd0;
				poll_d  = 8'd0;
			end
		end else begin
			tick_d = tc_inc;
			if (seg_end) begin
				tick_d = 16'd0;
				case (phase_q)
					PH_START, PH_RSTART: begin
						if (bit_q < 4'd2) begin
							bit_d = bit_q + 4'd1;
						end else begin
							phase_d = (phase_q == PH_START) ? PH_DEVW_TX : PH_DEVR_TX;
							bit_d   = 4'd0;
							poll_d  = 8'd0;
							shift_d = (phase_q == PH_START) ? dev_w : (dev_w | 8'd1);
						end
					end
					PH_DEVW_TX, PH_ADDR_TX, PH_DATA_TX, PH_DEVR_TX: begin
						if (bit_q != 4'd15) begin
							bit_d = bit_q + 4'd1;
						end else begin
							bit_d  = 4'd0;
							poll_d = 8'd0;
							case (phase_q)
								PH_DEVW_TX: phase_d = PH_DEVW_ACK;
								PH_ADDR_TX: phase_d = PH_ADDR_ACK;
								PH_DATA_TX: phase_d = PH_DATA_ACK;
								default:    phase_d = PH_DEVR_ACK;
							endcase
						end
					end
					PH_DEVW_ACK, PH_ADDR_ACK, PH_DATA_ACK, PH_DEVR_ACK: begin
						if (bit_q == 4'd0) begin
							bit_d = 4'd1;
						end else if (!item.sda_in) begin
							bit_d  = 4'd0;
							poll_d = 8'd0;
							case (phase_q)
								PH_DEVW_ACK: begin
									phase_d = PH_ADDR_TX;
									shift_d = addr_q;
								end
								PH_ADDR_ACK: begin
									if (op_q == ACT_WRITE || op_q == ACT_VERIFY) begin
										phase_d = PH_DATA_TX;
										shift_d = data_q;
									end else begin
										phase_d = PH_RSTART;
									end
								end
								PH_DATA_ACK: phase_d = PH_WSTOP;
								default: begin
									phase_d = PH_RX;
									shift_d = 8'd0;
								end
							endcase
						end else if (poll_q >= cfg.ack_poll_limit) begin
							phase_d = PH_FSTOP;
							bit_d   = 4'd0;
							poll_d  = 8'd0;
						end else begin
							poll_d = poll_q + 8'd1;
						end
					end
					PH_RX: begin
						if (bit_q[0]) begin
							shift_d = rx_shift;
						end
						if (bit_q != 4'd15) begin
							bit_d = bit_q + 4'd1;
						end else begin
							rx_d    = rx_shift;
							phase_d = PH_RX_NACK;
							bit_d   = 4'd0;
							poll_d  = 8'd0;
						end
					end
					PH_RX_NACK, PH_WSTOP: begin
						if (bit_q == 4'd0) begin
							bit_d = 4'd1;
						end else begin
							phase_d = (phase_q == PH_WSTOP) ? PH_WWAIT : PH_RSTOP;
							bit_d   = 4'd0;
							poll_d  = 8'd0;
						end
					end
					PH_RSTOP, PH_FSTOP: begin
						if (bit_q == 4'd0) begin
							bit_d = 4'd1;
						end else begin
							if (phase_q == PH_FSTOP) begin
								status_d = ST_NO_ACK;
							end else if (op_q == ACT_TICK) begin
								status_d = (rx_q == data_q) ? ST_OK : ST_MISMATCH;
							end else begin
								status_d = ST_OK;
							end
							phase_d = PH_IDLE;
							bit_d   = 4'd0;
							poll_d  = 8'd0;
							done_d  = 1'b1;
						end
					end
					PH_WWAIT: begin
						bit_d  = 4'd0;
						poll_d = 8'd0;
						if (op_q == ACT_VERIFY) begin
							op_d    = ACT_TICK;
							phase_d = PH_START;
						end else begin
							status_d = ST_OK;
							phase_d  = PH_IDLE;
							done_d   = 1'b1;
						end
					end
					default: begin
						phase_d = PH_IDLE;
						bit_d   = 4'd0;
						poll_d  = 8'd0;
					end
				endcase
			end
		end
	end

	// line levels after the step
	always_comb begin
		scl_d = 1'b1;
		sdl_d = 1'b1;
		en_d  = 1'b1;
		case (phase_d)
			PH_START, PH_RSTART: begin
				scl_d = bit_d != 4'd0;
				sdl_d = bit_d != 4'd2;
			end
			PH_DEVW_TX, PH_ADDR_TX, PH_DATA_TX, PH_DEVR_TX: begin
				scl_d = bit_d[0];
				sdl_d = shift_d[3'd7 - bit_d[3:1]];
			end
			PH_DEVW_ACK, PH_ADDR_ACK, PH_DATA_ACK, PH_DEVR_ACK, PH_RX: begin
				scl_d = bit_d[0];
				en_d  = 1'b0;
			end
			PH_RX_NACK: begin
				scl_d = bit_d[0];
			end
			PH_WSTOP, PH_RSTOP, PH_FSTOP: begin
				scl_d = bit_d[0];
				sdl_d = 1'b0;
			end
			default: begin
				scl_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bit_q    <= 4'd0;
			shift_q  <= 8'd0;
			tick_q   <= 16'd0;
			poll_q   <= 8'd0;
			op_q     <= ACT_TICK;
			addr_q   <= 8'd0;
			data_q   <= 8'd0;
			rx_q     <= 8'd0;
			status_q <= ST_OK;
		end else if (pop) begin
			phase_q  <= phase_d;
			bit_q    <= bit_d;
			shift_q  <= shift_d;
			tick_q   <= tick_d;
			poll_q   <= poll_d;
			op_q     <= op_d;
			addr_q   <= addr_d;
			data_q   <= data_d;
			rx_q     <= rx_d;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= {1'b0, status_d, rx_d, done_d, phase_d != PH_IDLE,
				en_d, sdl_d, scl_d};
		end
	end

endmodule

### rtl/core/i2c_eeprom_byte_master.sv
// Top level of the I2C EEPROM byte master: register port, input queue and bus sequencer.
// Each input word is one microsecond tick carrying a command code and the sampled SDA level;
// each tick yields exactly one result word with the SCL/SDA drive, busy, done, the last
// received byte and the status of the last command. One word is taken per clock cycle:
// a two-entry queue feeds the sequencer, which advances one tick per cycle into a
// registered output, so the rate is set only by the consumer taking results. A command
// arriving while a transfer is in progress is ignored. Registers may be written only while
// the block is idle; they are read back at byte offsets 0, 4, 8, 12 and 16.
module i2c_eeprom_byte_master import ieb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// [1:0] action, [9:2] mem_address, [17:10] write_data, [18] sda_in
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// [0] scl_level, [1] sda_level, [2] sda_enable, [3] busy_res, [4] done_res,
	// [12:5] read_data, [14:13] status
	output logic [OUT_W-1:0] m_tdata,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cfg_t  cfg_q;
	logic  cfg_wr;
	logic  item_valid;
	item_t item;
	logic  pop;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_bit_ticks    <= HALF_BIT_RST;
			cfg_q.ack_poll_limit    <= POLL_LIMIT_RST;
			cfg_q.ack_poll_interval <= POLL_INTERVAL_RST;
			cfg_q.write_wait_ticks  <= WRITE_WAIT_RST;
			cfg_q.device_select     <= DEVICE_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_HALF_BIT:      cfg_q.half_bit_ticks    <= pwdata[7:0];
				REG_POLL_LIMIT:    cfg_q.ack_poll_limit    <= pwdata[7:0];
				REG_POLL_INTERVAL: cfg_q.ack_poll_interval <= pwdata[15:0];
				REG_WRITE_WAIT:    cfg_q.write_wait_ticks  <= pwdata[15:0];
				REG_DEVICE:        cfg_q.device_select     <= pwdata[6:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_HALF_BIT:      prdata = {24'd0, cfg_q.half_bit_ticks};
			REG_POLL_LIMIT:    prdata = {24'd0, cfg_q.ack_poll_limit};
			REG_POLL_INTERVAL: prdata = {16'd0, cfg_q.ack_poll_interval};
			REG_WRITE_WAIT:    prdata = {16'd0, cfg_q.write_wait_ticks};
			REG_DEVICE:        prdata = {25'd0, cfg_q.device_select};
			default:           prdata = 32'd0;
		endcase
	end

	ieb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.pop        (pop),
		.item_valid (item_valid),
		.item       (item)
	);

	ieb_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the I2C EEPROM byte master: tick stream, bus emulation, prediction.
module testbench import ieb_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t    status;
		logic [7:0] read_data;
		logic       done;
		logic       busy;
		logic       sda_en;
		logic       sda_lv;
		logic       scl;
	} bus_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [4:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	i2c_eeprom_byte_master dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// sequencer copy
	logic [7:0]  cf_half;
	logic [7:0]  cf_limit;
	logic [15:0] cf_interval;
	logic [15:0] cf_wait;
	logic [6:0]  cf_dev;
	phase_t      sq_phase;
	logic [3:0]  sq_seg;
	logic [7:0]  sq_shift;
	logic [15:0] sq_ticks;
	logic [7:0]  sq_polls;
	action_t     sq_kind;
	logic [7:0]  sq_addr;
	logic [7:0]  sq_data;
	logic [7:0]  sq_rx;
	status_t     sq_status;

	bus_word_t   pending_bus_words[$];
	int          errors = 0;
	int          words_sent = 0;
	logic        calm = 1'b0;

	// EEPROM emulation plan for the current command
	int          plan_ack_pct;
	phase_t      plan_nack_ph;
	phase_t      plan_slow_ph;
	logic [7:0]  plan_rx;
	int          plan_noise;
	int          plan_pause;

	function automatic void enter(phase_t p);
		sq_phase = p;
		sq_seg = '0;
		sq_ticks = '0;
		sq_polls = '0;
	endfunction

	function automatic void enter_tx(phase_t p, logic [7:0] b);
		enter(p);
		sq_shift = b;
	endfunction

	function automatic void next_seg();
		sq_seg = sq_seg + 4'd1;
		sq_ticks = '0;
	endfunction

	function automatic bus_word_t next_bus_word(action_t act, logic [7:0] adr, logic [7:0] dat,
			logic sda);
		logic [15:0] dur;
		logic        fin;
		logic [7:0]  devw;
		bus_word_t   r;
		fin = 1'b0;
		devw = {cf_dev, 1'b0};
		if (sq_phase == PH_IDLE) begin
			if (act != ACT_TICK) begin
				sq_addr = adr;
				sq_data = dat;
				sq_kind = act;
				enter(PH_START);
			end
		end else begin
			if (sq_phase == PH_WWAIT)
				dur = cf_wait;
			else if ((sq_phase inside {PH_DEVW_ACK, PH_ADDR_ACK, PH_DATA_ACK, PH_DEVR_ACK}) &&
					sq_seg == 4'd1 && sq_polls != 8'd0)
				dur = cf_interval;
			else
				dur = {8'd0, cf_half};
			if (sq_ticks != 16'hFFFF)
				sq_ticks = sq_ticks + 16'd1;
			if (sq_ticks >= dur) begin
				case (sq_phase)
					PH_START, PH_RSTART: begin
						if (sq_seg < 4'd2)
							next_seg();
						else if (sq_phase == PH_START)
							enter_tx(PH_DEVW_TX, devw);
						else
							enter_tx(PH_DEVR_TX, devw | 8'd1);
					end
					PH_DEVW_TX, PH_ADDR_TX, PH_DATA_TX, PH_DEVR_TX: begin
						if (sq_seg < 4'd15)
							next_seg();
						else
							enter(phase_t'(sq_phase + 5'd1));
					end
					PH_DEVW_ACK, PH_ADDR_ACK, PH_DATA_ACK, PH_DEVR_ACK: begin
						if (sq_seg == 4'd0) begin
							next_seg();
						end else if (!sda) begin
							case (sq_phase)
								PH_DEVW_ACK: enter_tx(PH_ADDR_TX, sq_addr);
								PH_ADDR_ACK: begin
									if (sq_kind == ACT_WRITE || sq_kind == ACT_VERIFY)
										enter_tx(PH_DATA_TX, sq_data);
									else
										enter(PH_RSTART);
								end
								PH_DATA_ACK: enter(PH_WSTOP);
								default: begin
									enter(PH_RX);
									sq_shift = '0;
								end
							endcase
						end else if (sq_polls >= cf_limit) begin
							enter(PH_FSTOP);
						end else begin
							sq_polls = sq_polls + 8'd1;
							sq_ticks = '0;
						end
					end
					PH_RX: begin
						if (sq_seg[0])
							sq_shift = {sq_shift[6:0], sda};
						if (sq_seg < 4'd15) begin
							next_seg();
						end else begin
							sq_rx = sq_shift;
							enter(PH_RX_NACK);
						end
					end
					PH_RX_NACK, PH_WSTOP: begin
						if (sq_seg < 4'd1)
							next_seg();
						else
							enter(sq_phase == PH_WSTOP ? PH_WWAIT : PH_RSTOP);
					end
					PH_RSTOP, PH_FSTOP: begin
						if (sq_seg < 4'd1) begin
							next_seg();
						end else begin
							if (sq_phase == PH_FSTOP)
								sq_status = ST_NO_ACK;
							else if (sq_kind == ACT_TICK)
								sq_status = (sq_rx == sq_data) ? ST_OK : ST_MISMATCH;
							else
								sq_status = ST_OK;
							enter(PH_IDLE);
							fin = 1'b1;
						end
					end
					PH_WWAIT: begin
						if (sq_kind == ACT_VERIFY) begin
							sq_kind = ACT_TICK;
							enter(PH_START);
						end else begin
							sq_status = ST_OK;
							enter(PH_IDLE);
							fin = 1'b1;
						end
					end
					default: enter(PH_IDLE);
				endcase
			end
		end

		r.scl = 1'b1;
		r.sda_lv = 1'b1;
		r.sda_en = 1'b1;
		case (sq_phase)
			PH_START, PH_RSTART: begin
				r.scl = sq_seg != 4'd0;
				r.sda_lv = sq_seg != 4'd2;
			end
			PH_DEVW_TX, PH_ADDR_TX, PH_DATA_TX, PH_DEVR_TX: begin
				r.scl = sq_seg[0];
				r.sda_lv = sq_shift[3'd7 - sq_seg[3:1]];
			end
			PH_DEVW_ACK, PH_ADDR_ACK, PH_DATA_ACK, PH_DEVR_ACK, PH_RX: begin
				r.scl = sq_seg[0];
				r.sda_en = 1'b0;
			end
			PH_RX_NACK: r.scl = sq_seg[0];
			PH_WSTOP, PH_RSTOP, PH_FSTOP: begin
				r.scl = sq_seg[0];
				r.sda_lv = 1'b0;
			end
			default: ;
		endcase
		r.busy = sq_phase != PH_IDLE;
		r.done = fin;
		r.read_data = sq_rx;
		r.status = sq_status;
		return r;
	endfunction

	// SDA as the EEPROM would leave it for the coming tick
	function automatic logic bus_sda();
		if (sq_phase inside {PH_DEVW_ACK, PH_ADDR_ACK, PH_DATA_ACK, PH_DEVR_ACK}) begin
			if (sq_phase == plan_nack_ph)
				return 1'b1;
			if (sq_phase == plan_slow_ph && sq_polls == 8'd0)
				return 1'b1;
			return ($urandom_range(99) < plan_ack_pct) ? 1'b0 : 1'b1;
		end
		if (sq_phase == PH_RX)
			return plan_rx[3'd7 - sq_seg[3:1]];
		return 1'($urandom_range(1));
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	bus_word_t want_word;
	bus_word_t got_word;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_word = bus_word_t'(m_tdata[14:0]);
			if (pending_bus_words.size() == 0) begin
				$display("%0t ns: word expected none, got %0h", $time, m_tdata);
				errors++;
			end else begin
				want_word = pending_bus_words.pop_front();
				check_field("scl_level", want_word.scl, got_word.scl);
				check_field("sda_level", want_word.sda_lv, got_word.sda_lv);
				check_field("sda_enable", want_word.sda_en, got_word.sda_en);
				check_field("busy_res", want_word.busy, got_word.busy);
				check_field("done_res", want_word.done, got_word.done);
				check_field("read_data", want_word.read_data, got_word.read_data);
				check_field("status", want_word.status, got_word.status);
			end
		end
	end

	always @(negedge clk)
		m_tready <= calm || ($urandom_range(99) >= 7);

	task automatic send_tick(action_t act, logic [7:0] adr, logic [7:0] dat, logic sda);
		if (!calm && $urandom_range(99) < 7) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		s_tdata <= {5'd0, sda, dat, adr, act};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_bus_words.push_back(next_bus_word(act, adr, dat, sda));
		words_sent++;
		@(negedge clk);
	endtask

	task automatic wait_results();
		s_tvalid <= 1'b0;
		while (pending_bus_words.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_HALF_BIT:      cf_half = val[7:0];
			REG_POLL_LIMIT:    cf_limit = val[7:0];
			REG_POLL_INTERVAL: cf_interval = val[15:0];
			REG_WRITE_WAIT:    cf_wait = val[15:0];
			REG_DEVICE:        cf_dev = val[6:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(logic [7:0] half, logic [7:0] limit, logic [15:0] interval,
			logic [15:0] wwait, logic [6:0] dev);
		wait_results();
		write_reg(REG_HALF_BIT, {24'd0, half});
		write_reg(REG_POLL_LIMIT, {24'd0, limit});
		write_reg(REG_POLL_INTERVAL, {16'd0, interval});
		write_reg(REG_WRITE_WAIT, {16'd0, wwait});
		write_reg(REG_DEVICE, {25'd0, dev});
	endtask

	task automatic plan_clean();
		plan_ack_pct = 100;
		plan_nack_ph = PH_IDLE;
		plan_slow_ph = PH_IDLE;
		plan_rx = 8'($urandom);
		plan_noise = 3;
		plan_pause = -1;
	endtask

	task automatic run_command(action_t act, logic [7:0] adr, logic [7:0] dat);
		int n;
		n = 0;
		send_tick(act, adr, dat, 1'($urandom_range(1)));
		while (sq_phase != PH_IDLE) begin
			n++;
			if (n == plan_pause)
				wait_results();
			if ($urandom_range(99) < plan_noise)
				send_tick(action_t'($urandom_range(3, 1)), 8'($urandom), 8'($urandom), bus_sda());
			else
				send_tick(ACT_TICK, 8'($urandom), 8'($urandom), bus_sda());
		end
		repeat ($urandom_range(3))
			send_tick(ACT_TICK, 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
	endtask

	task automatic test_idle_and_defaults();
		plan_clean();
		for (int i = 0; i < 6; i++)
			send_tick(ACT_TICK, i[0] ? 8'hFF : 8'h00, i[0] ? 8'h00 : 8'hFF, i[0]);
		plan_rx = 8'hA5;
		run_command(ACT_READ, 8'h00, 8'h00);
	endtask

	task automatic test_field_extremes();
		plan_clean();
		set_config(8'd1, 8'd4, 16'd2, 16'd3, 7'h00);
		plan_rx = 8'hFF;
		run_command(ACT_READ, 8'hFF, 8'h00);
		set_config(8'd1, 8'd4, 16'd2, 16'd3, 7'h7F);
		run_command(ACT_WRITE, 8'h55, 8'hFF);
		plan_rx = 8'hC2;
		run_command(ACT_VERIFY, 8'hC3, 8'hC3);
	endtask

	task automatic test_missing_ack();
		plan_clean();
		set_config(8'd1, 8'd1, 16'd1, 16'd0, 7'h50);
		plan_nack_ph = PH_DEVW_ACK;
		run_command(ACT_READ, 8'h12, 8'h34);
		plan_nack_ph = PH_ADDR_ACK;
		run_command(ACT_WRITE, 8'h56, 8'h78);
		plan_nack_ph = PH_DATA_ACK;
		run_command(ACT_VERIFY, 8'h9A, 8'hBC);
		plan_nack_ph = PH_DEVR_ACK;
		run_command(ACT_VERIFY, 8'hDE, 8'hF0);
		plan_nack_ph = PH_IDLE;
		set_config(8'd1, 8'd40, 16'd1, 16'd0, 7'h50);
		plan_ack_pct = 0;
		run_command(ACT_READ, 8'h65, 8'h87);
		plan_ack_pct = 100;
		set_config(8'd1, 8'd1, 16'd20, 16'd0, 7'h50);
		plan_slow_ph = PH_DEVW_ACK;
		run_command(ACT_WRITE, 8'hA9, 8'hCB);
		plan_slow_ph = PH_IDLE;
	endtask

	task automatic test_segment_extremes();
		plan_clean();
		set_config(8'd0, 8'd0, 16'd0, 16'd0, 7'h50);
		plan_rx = 8'h69;
		run_command(ACT_VERIFY, 8'h7E, 8'h69);
	endtask

	task automatic test_busy_commands();
		plan_clean();
		set_config(8'd1, 8'd2, 16'd1, 16'd5, 7'h2A);
		plan_noise = 50;
		calm = 1'b1;
		run_command(ACT_READ, 8'h0A, 8'hA0);
		calm = 1'b0;
		plan_rx = 8'h11;
		plan_pause = 30;
		run_command(ACT_VERIFY, 8'hB0, 8'h11);
	endtask

	task automatic test_random_traffic();
		int      stop_at;
		int      n;
		action_t act;
		logic [7:0] adr;
		logic [7:0] dat;
		stop_at = 1650;
		n = 0;
		while (words_sent < stop_at) begin
			if (n == 0 || $urandom_range(99) < 15)
				set_config(($urandom_range(19) == 0) ? 8'($urandom_range(6, 4)) :
					8'($urandom_range(3, 1)), 8'($urandom_range(6, 1)),
					16'($urandom_range(8, 1)), 16'($urandom_range(20)), 7'($urandom));
			plan_clean();
			case ($urandom_range(19))
				0: plan_ack_pct = 0;
				1, 2, 3: plan_ack_pct = 70;
				default: plan_ack_pct = 100;
			endcase
			if ($urandom_range(19) == 0)
				case ($urandom_range(3))
					0: plan_nack_ph = PH_DEVW_ACK;
					1: plan_nack_ph = PH_ADDR_ACK;
					2: plan_nack_ph = PH_DATA_ACK;
					default: plan_nack_ph = PH_DEVR_ACK;
				endcase
			if ($urandom_range(99) < 3)
				plan_pause = $urandom_range(60, 1);
			act = action_t'($urandom_range(3, 1));
			adr = 8'($urandom);
			dat = 8'($urandom);
			if (act == ACT_VERIFY && $urandom_range(4) != 0)
				plan_rx = dat;
			run_command(act, adr, dat);
			n++;
		end
		calm = 1'b0;
	endtask

	initial begin
		cf_half = HALF_BIT_RST;
		cf_limit = POLL_LIMIT_RST;
		cf_interval = POLL_INTERVAL_RST;
		cf_wait = WRITE_WAIT_RST;
		cf_dev = DEVICE_RST;
		enter(PH_IDLE);
		sq_shift = '0;
		sq_kind = ACT_TICK;
		sq_addr = '0;
		sq_data = '0;
		sq_rx = '0;
		sq_status = ST_OK;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_idle_and_defaults();
		test_field_extremes();
		test_missing_ack();
		test_segment_extremes();
		test_busy_commands();
		test_random_traffic();
		wait_results();
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		#24_000_000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule

### i2c_eeprom_byte_master.f
rtl/core/ieb_pkg.sv
rtl/core/ieb_front.sv
rtl/core/ieb_engine.sv
rtl/core/i2c_eeprom_byte_master.sv
tb/sv/testbench.sv
